// ----- sv/ddo_pkg.sv -----
`default_nettype none

package ddo_pkg;

    // Default build values for the top-level parameters.
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int POSITION_BITS_DEF = 32;

    // Width of an index into the arctangent table.
    localparam int ANGLE_IDX_W = 5;

    // Beat widths of the two streams, and index and data widths of the register port.
    localparam int S_DATA_W   = 96;
    localparam int M_DATA_W   = 144;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Reset value of the scale and gain registers (1.0 in Q16.16).
    localparam logic [31:0] UNITY_Q16 = 32'h0001_0000;

    // CORDIC gain compensation, 1/K as an unsigned 0.32 fraction.
    localparam logic [31:0] GAIN_COMP = 32'h9B74_EDA8;

    // 2*pi in Q16.16, used to turn a binary angle into radians.
    localparam logic signed [19:0] TWO_PI_Q16 = 20'sd411775;

    // Clamp applied to every gain product, and the matching limit on the
    // high partial product when the result is taken as a Q16.16 product.
    localparam logic [63:0] MUL_LIMIT    = 64'h1000_0000_0000_0000;
    localparam logic [63:0] MUL_LIMIT_HI = 64'h0000_1000_0000_0000;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEFT_SCALE  = 3'd0,
        CFG_RIGHT_SCALE = 3'd1,
        CFG_HEAD_PER_D  = 3'd2,
        CFG_DIST_GAIN   = 3'd3,
        CFG_HEAD_GAIN   = 3'd4,
        CFG_START_X     = 3'd5,
        CFG_START_Y     = 3'd6,
        CFG_START_HEAD  = 3'd7
    } cfg_idx_t;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE    = 4'd0,
        OP_CAPTURE = 4'd1,
        OP_LOAD    = 4'd2,
        OP_VPRE    = 4'd3,
        OP_VITER   = 4'd4,
        OP_MS_A    = 4'd5,
        OP_MS_B    = 4'd6,
        OP_ERR     = 4'd7,
        OP_CMD     = 4'd8,
        OP_WHEEL   = 4'd9,
        OP_DIFF    = 4'd10,
        OP_HMUL    = 4'd11,
        OP_MID     = 4'd12,
        OP_RITER   = 4'd13,
        OP_POSE    = 4'd14,
        OP_OUT     = 4'd15
    } op_t;

    // Operand and destination of the shared multiply-saturate unit.
    typedef enum logic [2:0] {
        MS_DIST = 3'd0,
        MS_T1   = 3'd1,
        MS_T2   = 3'd2,
        MS_RX   = 3'd3,
        MS_RY   = 3'd4
    } msel_t;

    // Command word from the controller to the datapath.
    typedef struct packed {
        op_t                    op;
        msel_t                  msel;
        logic [ANGLE_IDX_W-1:0] idx;
    } ddo_cmd_t;

    // Arctangent of 2^-i as a 32-bit binary angle.
    function automatic logic [31:0] atan_lookup(input logic [ANGLE_IDX_W-1:0] i);
        logic [31:0] a;
        case (i)
            5'd0:    a = 32'h2000_0000;
            5'd1:    a = 32'h12E4_051E;
            5'd2:    a = 32'h09FB_385B;
            5'd3:    a = 32'h0511_11D4;
            5'd4:    a = 32'h028B_0D43;
            5'd5:    a = 32'h0145_D7E1;
            5'd6:    a = 32'h00A2_F61E;
            5'd7:    a = 32'h0051_7C55;
            5'd8:    a = 32'h0028_BE53;
            5'd9:    a = 32'h0014_5F2F;
            5'd10:   a = 32'h000A_2F98;
            5'd11:   a = 32'h0005_17CC;
            5'd12:   a = 32'h0002_8BE6;
            5'd13:   a = 32'h0001_45F3;
            5'd14:   a = 32'h0000_A2FA;
            5'd15:   a = 32'h0000_517D;
            5'd16:   a = 32'h0000_28BE;
            5'd17:   a = 32'h0000_145F;
            5'd18:   a = 32'h0000_0A30;
            5'd19:   a = 32'h0000_0518;
            5'd20:   a = 32'h0000_028C;
            5'd21:   a = 32'h0000_0146;
            5'd22:   a = 32'h0000_00A3;
            5'd23:   a = 32'h0000_0051;
            5'd24:   a = 32'h0000_0029;
            5'd25:   a = 32'h0000_0014;
            5'd26:   a = 32'h0000_000A;
            5'd27:   a = 32'h0000_0005;
            5'd28:   a = 32'h0000_0003;
            5'd29:   a = 32'h0000_0001;
            5'd30:   a = 32'h0000_0001;
            default: a = 32'h0000_0000;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

// ----- sv/diff_drive_odometry_goal_control.sv -----
// Each item runs two CORDIC passes, vectoring then rotation, in the shared iteration unit.
// Items are processed one at a time; a new input beat is taken only while idle.
// The result register lets a new item start while the last result waits.
// Reset (aresetn, synchronous, active low) clears the sequencer and output valid,
// sets scales and gains to 1.0 and puts the pose at the origin with zero heading.
`default_nettype none

module diff_drive_odometry_goal_control #(
    parameter int CORDIC_STAGES = ddo_pkg::CORDIC_STAGES_DEF,
    parameter int POSITION_BITS = ddo_pkg::POSITION_BITS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // left_steps, right_steps, goal_x, goal_y
    input  wire logic [ddo_pkg::S_DATA_W-1:0]    s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // left_wheel_cmd, right_wheel_cmd, new_x, new_y, new_heading
    output logic      [ddo_pkg::M_DATA_W-1:0]    m_tdata,
    input  wire logic                            cfg_we,
    input  wire logic [ddo_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ddo_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import ddo_pkg::*;

    ddo_cmd_t cmd;

    ddo_ctrl #(
        .CORDIC_STAGES(CORDIC_STAGES)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .cmd     (cmd)
    );

    ddo_datapath #(
        .POSITION_BITS(POSITION_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .s_tdata  (s_tdata),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

// ----- sv/ddo_ctrl.sv -----
`default_nettype none

module ddo_ctrl #(
    parameter int CORDIC_STAGES = ddo_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output ddo_pkg::ddo_cmd_t      cmd
);
    import ddo_pkg::*;

    localparam int IW = $clog2(CORDIC_STAGES);
    localparam logic [IW-1:0] LAST_ITER = IW'(CORDIC_STAGES - 1);

    typedef enum logic [22:0] {
        S_IDLE    = 23'h000001,
        S_LOAD    = 23'h000002,
        S_VPRE    = 23'h000004,
        S_VITER   = 23'h000008,
        S_MDIST_A = 23'h000010,
        S_MDIST_B = 23'h000020,
        S_ERR     = 23'h000040,
        S_MT1_A   = 23'h000080,
        S_MT1_B   = 23'h000100,
        S_MT2_A   = 23'h000200,
        S_MT2_B   = 23'h000400,
        S_CMD     = 23'h000800,
        S_WHEEL   = 23'h001000,
        S_DIFF    = 23'h002000,
        S_HMUL    = 23'h004000,
        S_MID     = 23'h008000,
        S_RITER   = 23'h010000,
        S_MRX_A   = 23'h020000,
        S_MRX_B   = 23'h040000,
        S_MRY_A   = 23'h080000,
        S_MRY_B   = 23'h100000,
        S_POSE    = 23'h200000,
        S_DONE    = 23'h400000
    } state_t;

    state_t        state_reg, state_next;
    logic [IW-1:0] iter_reg, iter_next;
    logic          valid_reg, valid_next;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = valid_reg;

    // Sequencer: goal control first, then odometry integration.
    always_comb begin
        state_next = state_reg;
        iter_next  = iter_reg;
        valid_next = valid_reg && !m_tready;
        cmd.op     = OP_NONE;
        cmd.msel   = MS_DIST;
        cmd.idx    = ANGLE_IDX_W'(iter_reg);
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = OP_CAPTURE;
                    state_next = S_LOAD;
                end
            end
            S_LOAD: begin
                cmd.op     = OP_LOAD;
                state_next = S_VPRE;
            end
            S_VPRE: begin
                cmd.op     = OP_VPRE;
                iter_next  = '0;
                state_next = S_VITER;
            end
            S_VITER: begin
                cmd.op = OP_VITER;
                if (iter_reg == LAST_ITER) begin
                    iter_next  = '0;
                    state_next = S_MDIST_A;
                end else begin
                    iter_next = iter_reg + 1'b1;
                end
            end
            S_MDIST_A: begin
                cmd.op     = OP_MS_A;
                cmd.msel   = MS_DIST;
                state_next = S_MDIST_B;
            end
            S_MDIST_B: begin
                cmd.op     = OP_MS_B;
                cmd.msel   = MS_DIST;
                state_next = S_ERR;
            end
            S_ERR: begin
                cmd.op     = OP_ERR;
                state_next = S_MT1_A;
            end
            S_MT1_A: begin
                cmd.op     = OP_MS_A;
                cmd.msel   = MS_T1;
                state_next = S_MT1_B;
            end
            S_MT1_B: begin
                cmd.op     = OP_MS_B;
                cmd.msel   = MS_T1;
                state_next = S_MT2_A;
            end
            S_MT2_A: begin
                cmd.op     = OP_MS_A;
                cmd.msel   = MS_T2;
                state_next = S_MT2_B;
            end
            S_MT2_B: begin
                cmd.op     = OP_MS_B;
                cmd.msel   = MS_T2;
                state_next = S_CMD;
            end
            S_CMD: begin
                cmd.op     = OP_CMD;
                state_next = S_WHEEL;
            end
            S_WHEEL: begin
                cmd.op     = OP_WHEEL;
                state_next = S_DIFF;
            end
            S_DIFF: begin
                cmd.op     = OP_DIFF;
                state_next = S_HMUL;
            end
            S_HMUL: begin
                cmd.op     = OP_HMUL;
                state_next = S_MID;
            end
            S_MID: begin
                cmd.op     = OP_MID;
                iter_next  = '0;
                state_next = S_RITER;
            end
            S_RITER: begin
                cmd.op = OP_RITER;
                if (iter_reg == LAST_ITER) begin
                    iter_next  = '0;
                    state_next = S_MRX_A;
                end else begin
                    iter_next = iter_reg + 1'b1;
                end
            end
            S_MRX_A: begin
                cmd.op     = OP_MS_A;
                cmd.msel   = MS_RX;
                state_next = S_MRX_B;
            end
            S_MRX_B: begin
                cmd.op     = OP_MS_B;
                cmd.msel   = MS_RX;
                state_next = S_MRY_A;
            end
            S_MRY_A: begin
                cmd.op     = OP_MS_A;
                cmd.msel   = MS_RY;
                state_next = S_MRY_B;
            end
            S_MRY_B: begin
                cmd.op     = OP_MS_B;
                cmd.msel   = MS_RY;
                state_next = S_POSE;
            end
            S_POSE: begin
                cmd.op     = OP_POSE;
                state_next = S_DONE;
            end
            S_DONE: begin
                // Wait until the output register is free.
                if (!valid_reg || m_tready) begin
                    cmd.op     = OP_OUT;
                    valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            iter_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
            valid_reg <= valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/ddo_datapath.sv -----
`default_nettype none

module ddo_datapath #(
    parameter int POSITION_BITS = ddo_pkg::POSITION_BITS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire ddo_pkg::ddo_cmd_t                cmd,
    input  wire logic [ddo_pkg::S_DATA_W-1:0]     s_tdata,
    input  wire logic                             cfg_we,
    input  wire logic [ddo_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [ddo_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output logic      [ddo_pkg::M_DATA_W-1:0]     m_tdata
);
    import ddo_pkg::*;

    localparam logic signed [63:0] POS_MAX = (64'sd1 <<< (POSITION_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] POS_MIN = -POS_MAX - 64'sd1;
    localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

    function automatic logic signed [POSITION_BITS-1:0] sat_pos(input logic signed [63:0] v);
        logic signed [63:0] c;
        c = (v > POS_MAX) ? POS_MAX : ((v < POS_MIN) ? POS_MIN : v);
        return POSITION_BITS'(c);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] c;
        c = (v > S32_MAX) ? S32_MAX : ((v < S32_MIN) ? S32_MIN : v);
        return c[31:0];
    endfunction

    // Configuration and pose.
    logic [31:0]                     lscale_reg, rscale_reg, hpd_reg, dgain_reg, hgain_reg;
    logic signed [POSITION_BITS-1:0] pose_x_reg, pose_y_reg;
    logic [15:0]                     pose_head_reg;

    // Working registers.
    logic signed [15:0] ls_reg, rs_reg;
    logic signed [31:0] gx_reg, gy_reg;
    logic signed [63:0] cx_reg, cy_reg;
    logic [31:0]        cz_reg;
    logic               vzero_reg;
    logic [63:0]        p_hi_reg, p_lo_reg;
    logic               ms_neg_reg, ms_sh16_reg;
    logic signed [63:0] dist_reg, t1_reg, t2_reg, rx_reg, ry_reg;
    logic signed [51:0] eprod_reg;
    logic signed [31:0] cmdl_reg, cmdr_reg;
    logic signed [48:0] dl_reg, dr_reg;
    logic signed [49:0] diff_reg;
    logic [63:0]        pa_reg;
    logic [48:0]        pb_reg;
    logic [15:0]        dcnt_reg;
    logic [M_DATA_W-1:0] out_reg;

    logic signed [63:0] pose_x64, pose_y64;
    logic signed [63:0] sh_x, sh_y;
    logic [31:0]        atan_val;
    logic signed [63:0] ms_a;
    logic [31:0]        ms_k;
    logic               ms_sh16;
    logic [63:0]        ms_u;
    logic               ms_over;
    logic [63:0]        ms_sum, ms_r;
    logic signed [63:0] ms_res;
    logic [31:0]        bearing, d32;
    logic signed [49:0] wsum;
    logic [16:0]        hsum;
    logic [15:0]        mid;
    logic [31:0]        ang, ang_chk;

    assign pose_x64 = 64'(pose_x_reg);
    assign pose_y64 = 64'(pose_y_reg);
    assign sh_x     = cx_reg >>> cmd.idx;
    assign sh_y     = cy_reg >>> cmd.idx;
    assign atan_val = atan_lookup(cmd.idx);
    assign bearing  = vzero_reg ? 32'h0 : cz_reg;
    assign d32      = bearing - {pose_head_reg, 16'h0};
    assign wsum     = 50'(dl_reg) + 50'(dr_reg);

    // Heading change in counts; half of it gives the midpoint heading.
    assign hsum    = pa_reg[48:32] + pb_reg[16:0];
    assign mid     = pose_head_reg + hsum[16:1];
    assign ang     = {mid, 16'h0};
    assign ang_chk = ang + 32'h4000_0000;

    // Operand selection for the multiply-saturate unit.
    always_comb begin
        ms_a    = cx_reg;
        ms_k    = GAIN_COMP;
        ms_sh16 = 1'b0;
        case (cmd.msel)
            MS_DIST: ms_a = cx_reg;
            MS_T1: begin
                ms_a    = dist_reg;
                ms_k    = dgain_reg;
                ms_sh16 = 1'b1;
            end
            MS_T2: begin
                ms_a    = 64'(eprod_reg >>> 32);
                ms_k    = hgain_reg;
                ms_sh16 = 1'b1;
            end
            MS_RX:   ms_a = cx_reg;
            MS_RY:   ms_a = cy_reg;
            default: ms_a = cx_reg;
        endcase
        ms_u = (ms_a < 0) ? 64'(-ms_a) : 64'(ms_a);
    end

    // Recombine partial products, truncate toward zero and clamp.
    always_comb begin
        if (ms_sh16_reg) begin
            ms_over = p_hi_reg > MUL_LIMIT_HI;
            ms_sum  = {p_hi_reg[47:0], 16'h0} + {16'h0, p_lo_reg[63:16]};
        end else begin
            ms_over = p_hi_reg > MUL_LIMIT;
            ms_sum  = p_hi_reg + {32'h0, p_lo_reg[63:32]};
        end
        ms_r   = (ms_over || (ms_sum > MUL_LIMIT)) ? MUL_LIMIT : ms_sum;
        ms_res = ms_neg_reg ? -$signed(ms_r) : $signed(ms_r);
    end

    // Configuration registers and pose.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lscale_reg    <= UNITY_Q16;
            rscale_reg    <= UNITY_Q16;
            hpd_reg       <= UNITY_Q16;
            dgain_reg     <= UNITY_Q16;
            hgain_reg     <= UNITY_Q16;
            pose_x_reg    <= '0;
            pose_y_reg    <= '0;
            pose_head_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_LEFT_SCALE:  lscale_reg    <= cfg_wdata;
                CFG_RIGHT_SCALE: rscale_reg    <= cfg_wdata;
                CFG_HEAD_PER_D:  hpd_reg       <= cfg_wdata;
                CFG_DIST_GAIN:   dgain_reg     <= cfg_wdata;
                CFG_HEAD_GAIN:   hgain_reg     <= cfg_wdata;
                CFG_START_X:     pose_x_reg    <= sat_pos(64'($signed(cfg_wdata)));
                CFG_START_Y:     pose_y_reg    <= sat_pos(64'($signed(cfg_wdata)));
                CFG_START_HEAD:  pose_head_reg <= cfg_wdata[15:0];
                default: ;
            endcase
        end else if (cmd.op == OP_POSE) begin
            pose_x_reg    <= sat_pos(pose_x64 + rx_reg);
            pose_y_reg    <= sat_pos(pose_y64 + ry_reg);
            pose_head_reg <= pose_head_reg + dcnt_reg;
        end
    end

    // Working datapath, one operation per cycle.
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_CAPTURE: begin
                ls_reg <= s_tdata[15:0];
                rs_reg <= s_tdata[31:16];
                gx_reg <= s_tdata[63:32];
                gy_reg <= s_tdata[95:64];
            end
            OP_LOAD: begin
                cx_reg <= 64'(gx_reg) - pose_x64;
                cy_reg <= 64'(gy_reg) - pose_y64;
            end
            OP_VPRE: begin
                vzero_reg <= (cx_reg == 0) && (cy_reg == 0);
                if (cx_reg < 0) begin
                    cx_reg <= -cx_reg;
                    cy_reg <= -cy_reg;
                    cz_reg <= 32'h8000_0000;
                end else begin
                    cz_reg <= 32'h0;
                end
            end
            OP_VITER: begin
                if (cy_reg >= 0) begin
                    cx_reg <= cx_reg + sh_y;
                    cy_reg <= cy_reg - sh_x;
                    cz_reg <= cz_reg + atan_val;
                end else begin
                    cx_reg <= cx_reg - sh_y;
                    cy_reg <= cy_reg + sh_x;
                    cz_reg <= cz_reg - atan_val;
                end
            end
            OP_MS_A: begin
                p_hi_reg    <= ms_u[63:32] * ms_k;
                p_lo_reg    <= ms_u[31:0] * ms_k;
                ms_neg_reg  <= ms_a < 0;
                ms_sh16_reg <= ms_sh16;
            end
            OP_MS_B: begin
                case (cmd.msel)
                    MS_DIST: dist_reg <= ms_res;
                    MS_T1:   t1_reg   <= ms_res;
                    MS_T2:   t2_reg   <= ms_res;
                    MS_RX:   rx_reg   <= ms_res;
                    MS_RY:   ry_reg   <= ms_res;
                    default: ;
                endcase
            end
            OP_ERR: eprod_reg <= $signed(d32) * TWO_PI_Q16;
            OP_CMD: begin
                cmdl_reg <= sat32(t1_reg + t2_reg);
                cmdr_reg <= sat32(t1_reg - t2_reg);
            end
            OP_WHEEL: begin
                dl_reg <= ls_reg * $signed({1'b0, lscale_reg});
                dr_reg <= rs_reg * $signed({1'b0, rscale_reg});
            end
            OP_DIFF: begin
                cx_reg   <= 64'(wsum >>> 1);
                cy_reg   <= '0;
                diff_reg <= 50'(dr_reg) - 50'(dl_reg);
            end
            OP_HMUL: begin
                pa_reg <= diff_reg[31:0] * hpd_reg;
                pb_reg <= diff_reg[48:32] * hpd_reg;
            end
            OP_MID: begin
                dcnt_reg <= hsum[15:0];
                // Fold the angle into the right half plane.
                if (ang_chk[31]) begin
                    cx_reg <= -cx_reg;
                    cz_reg <= ang + 32'h8000_0000;
                end else begin
                    cz_reg <= ang;
                end
            end
            OP_RITER: begin
                if (!cz_reg[31]) begin
                    cx_reg <= cx_reg - sh_y;
                    cy_reg <= cy_reg + sh_x;
                    cz_reg <= cz_reg - atan_val;
                end else begin
                    cx_reg <= cx_reg + sh_y;
                    cy_reg <= cy_reg - sh_x;
                    cz_reg <= cz_reg + atan_val;
                end
            end
            OP_OUT: begin
                out_reg <= {pose_head_reg, pose_y64[31:0], pose_x64[31:0], cmdr_reg, cmdl_reg};
            end
            default: ;
        endcase
    end

    assign m_tdata = out_reg;

endmodule

`default_nettype wire

// ----- sv/ddo_checker.sv -----
`default_nettype none

module ddo_checker (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         s_tvalid,
    input wire logic                         s_tready,
    input wire logic                         m_tvalid,
    input wire logic                         m_tready,
    input wire logic [ddo_pkg::M_DATA_W-1:0] m_tdata
);
    // Reset leaves the block empty and ready.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("block not idle after reset");

    // After an accepted item the block is busy and not ready for the next one.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
        else $error("input taken again too soon");

    // A stalled result beat stays offered.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    // A stalled result beat keeps its payload.
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result payload changed while stalled");

endmodule

bind diff_drive_odometry_goal_control ddo_checker u_chk (.*);

`default_nettype wire

// ----- sim/testbench.sv -----
`default_nettype none

module testbench;
    import ddo_pkg::*;

    localparam int STAGES      = 16;
    localparam int STALL_LIMIT = 3000;
    localparam int SETTLE      = 60;

    typedef struct {
        logic [15:0] left_steps;
        logic [15:0] right_steps;
        logic [31:0] goal_x;
        logic [31:0] goal_y;
    } wheel_item_t;

    typedef struct {
        logic [31:0] left_cmd;
        logic [31:0] right_cmd;
        logic [31:0] x;
        logic [31:0] y;
        logic [15:0] heading;
    } pose_result_t;

    // Arctangent of 2^-i as a 32-bit binary angle.
    localparam logic [31:0] ATAN_ANGLE [STAGES] = '{
        32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
        32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
        32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
        32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D
    };

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_we = 1'b0;
    cfg_idx_t              cfg_index = CFG_LEFT_SCALE;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    wheel_item_t  step_queue[$];
    pose_result_t pose_expect[$];

    // Shadow copy of the registers and pose.
    logic [31:0] reg_shadow [8];
    longint      pose_x, pose_y;
    logic [15:0] pose_hd;

    int  mismatches = 0;
    int  stall_count = 0;
    bit  calm = 1'b0;
    bit  beat_in_taken = 1'b0;
    int  in_gap = 0;
    int  out_gap = 0;

    diff_drive_odometry_goal_control DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #10 aclk = ~aclk;

    // Gap length: mostly none or short, now and then long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 45) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // a * k / 2^sh truncated toward zero, magnitude clamped to 2^60.
    function automatic longint scale_clamp(longint a, logic [31:0] k, int sh);
        bit          neg;
        logic [63:0] u, hi, lo, hp, r, kk;
        int          up;
        neg = a < 0;
        u   = neg ? 64'(-a) : 64'(a);
        kk  = {32'b0, k};
        hi  = u >> 32;
        lo  = u & 64'hFFFF_FFFF;
        hp  = hi * kk;
        up  = 32 - sh;
        if (hp > (MUL_LIMIT >> up)) begin
            r = MUL_LIMIT;
        end else begin
            r = (hp << up) + ((lo * kk) >> sh);
            if (r > MUL_LIMIT) r = MUL_LIMIT;
        end
        return neg ? -longint'(r) : longint'(r);
    endfunction

    // Distance and bearing of a vector by CORDIC vectoring.
    task automatic goal_vector(input longint dx, input longint dy,
                               output longint gdist, output logic [31:0] bearing);
        longint x, y, z, t;
        if (dx == 0 && dy == 0) begin
            gdist = 0;
            bearing = '0;
            return;
        end
        x = dx;
        y = dy;
        z = 0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 64'sh8000_0000;
        end
        for (int i = 0; i < STAGES; i++) begin
            t = x;
            if (y >= 0) begin
                x = x + (y >>> i);
                y = y - (t >>> i);
                z = z + ATAN_ANGLE[i];
            end else begin
                x = x - (y >>> i);
                y = y + (t >>> i);
                z = z - ATAN_ANGLE[i];
            end
        end
        gdist = scale_clamp(x, GAIN_COMP, 32);
        bearing = z[31:0];
    endtask

    // Displacement of length mag along a binary angle by CORDIC rotation.
    task automatic heading_rotate(input longint mag, input logic [31:0] ang_in,
                                  output longint ox, output longint oy);
        longint      x, y, z, t;
        logic [31:0] ang, probe;
        x = mag;
        y = 0;
        ang = ang_in;
        probe = ang + 32'h4000_0000;
        if (probe[31]) begin
            x = -x;
            ang = ang + 32'h8000_0000;
        end
        z = longint'($signed(ang));
        for (int i = 0; i < STAGES; i++) begin
            t = x;
            if (z >= 0) begin
                x = x - (y >>> i);
                y = y + (t >>> i);
                z = z - ATAN_ANGLE[i];
            end else begin
                x = x + (y >>> i);
                y = y - (t >>> i);
                z = z + ATAN_ANGLE[i];
            end
        end
        ox = scale_clamp(x, GAIN_COMP, 32);
        oy = scale_clamp(y, GAIN_COMP, 32);
    endtask

    // Commands from the current pose, then the pose update from the steps.
    task automatic odometry_step(input logic [S_DATA_W-1:0] beat);
        longint       ls, rs, gx, gy, gdist, err, err_rad, t1, t2, dl, dr, dd, rx, ry;
        logic [31:0]  bearing, d32;
        logic [63:0]  prod;
        logic [15:0]  mid;
        pose_result_t res;
        ls = longint'($signed(beat[15:0]));
        rs = longint'($signed(beat[31:16]));
        gx = longint'($signed(beat[63:32]));
        gy = longint'($signed(beat[95:64]));
        goal_vector(gx - pose_x, gy - pose_y, gdist, bearing);
        d32 = bearing - {pose_hd, 16'h0};
        err = longint'($signed(d32));
        err_rad = (err * 64'sd411775) >>> 32;
        t1 = scale_clamp(gdist, reg_shadow[CFG_DIST_GAIN], 16);
        t2 = scale_clamp(err_rad, reg_shadow[CFG_HEAD_GAIN], 16);
        res.left_cmd  = 32'(sat32(t1 + t2));
        res.right_cmd = 32'(sat32(t1 - t2));
        dl = ls * longint'({32'b0, reg_shadow[CFG_LEFT_SCALE]});
        dr = rs * longint'({32'b0, reg_shadow[CFG_RIGHT_SCALE]});
        dd = (dl + dr) >>> 1;
        prod = 64'(dr - dl) * {32'b0, reg_shadow[CFG_HEAD_PER_D]};
        mid = pose_hd + prod[48:33];
        heading_rotate(dd, {mid, 16'h0}, rx, ry);
        pose_x  = sat32(pose_x + rx);
        pose_y  = sat32(pose_y + ry);
        pose_hd = pose_hd + prod[47:32];
        res.x       = 32'(pose_x);
        res.y       = 32'(pose_y);
        res.heading = pose_hd;
        pose_expect.push_back(res);
    endtask

    // Register write on the configuration port, mirrored in the shadow copy.
    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        reg_shadow[idx] = val;
        case (idx)
            CFG_START_X:    pose_x = longint'($signed(val));
            CFG_START_Y:    pose_y = longint'($signed(val));
            CFG_START_HEAD: begin
                reg_shadow[idx] = {16'h0, val[15:0]};
                pose_hd = val[15:0];
            end
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Block until everything sent has come back, then let the block settle.
    // The check runs at the rising edge, where the driver's signals are steady.
    task automatic drain();
        do @(posedge aclk);
        while (step_queue.size() != 0 || s_tvalid || pose_expect.size() != 0);
        repeat (SETTLE) @(negedge aclk);
    endtask

    function automatic logic [31:0] pick_reg();
        case ($urandom_range(0, 4))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            2:       return UNITY_Q16;
            3:       return $urandom;
            default: return $urandom_range(0, 1 << 20);
        endcase
    endfunction

    function automatic void push_item(logic [15:0] ls, logic [15:0] rs,
                                      logic [31:0] gx, logic [31:0] gy);
        wheel_item_t it;
        it.left_steps  = ls;
        it.right_steps = rs;
        it.goal_x      = gx;
        it.goal_y      = gy;
        step_queue.push_back(it);
    endfunction

    function automatic logic [15:0] rand_steps();
        if ($urandom_range(0, 99) < 70) return 16'($signed($urandom_range(0, 4000)) - 2000);
        return $urandom;
    endfunction

    function automatic logic [31:0] rand_goal(longint near);
        if ($urandom_range(0, 99) < 50) return $urandom;
        return 32'(near + longint'($signed($urandom_range(0, 1 << 25))) - (1 << 24));
    endfunction

    // Stimulus: a directed opening, then phases under changing registers.
    initial begin
        logic [31:0] val;
        reg_shadow = '{UNITY_Q16, UNITY_Q16, UNITY_Q16, UNITY_Q16, UNITY_Q16, 0, 0, 0};
        pose_x = 0;
        pose_y = 0;
        pose_hd = '0;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        for (int p = 0; p < 8; p++) begin
            if (p > 0) begin
                drain();
                for (int i = 0; i < 8; i++) begin
                    case (p)
                        1:       val = 32'h0;
                        2:       val = 32'hFFFF_FFFF;
                        3:       val = (i == CFG_START_X) ? 32'h7FFF_FFFF :
                                       (i == CFG_START_Y) ? 32'h8000_0000 : UNITY_Q16;
                        default: val = pick_reg();
                    endcase
                    write_reg(cfg_idx_t'(i), val);
                end
            end
            calm = (p == 4);

            // Goal placed exactly on the pose: bearing falls back to zero.
            push_item(16'h0, 16'h0, 32'(pose_x), 32'(pose_y));
            if (p == 0) begin
                // Extreme steps drive the position into saturation.
                push_item(16'h7FFF, 16'h7FFF, 32'h7FFF_FFFF, 32'h8000_0000);
                push_item(16'h7FFF, 16'h7FFF, 32'h8000_0000, 32'h7FFF_FFFF);
                push_item(16'h8000, 16'h8000, 32'hFFFF_FFFF, 32'h0);
                push_item(16'h8000, 16'h8000, 32'h0, 32'h0000_0001);
                push_item(16'h8000, 16'h8000, 32'h8000_0000, 32'h8000_0000);
                // Spins in both directions wrap the heading.
                push_item(16'h8000, 16'h7FFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
                push_item(16'h8000, 16'h7FFF, 32'h0001_0000, 32'hFFFF_0000);
                push_item(16'h7FFF, 16'h8000, 32'h0, 32'h8000_0000);
                push_item(16'h7FFF, 16'h8000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                push_item(16'h0001, 16'hFFFF, 32'h0, 32'h0);
                push_item(16'hFFFF, 16'h0001, 32'h7FFF_FFFF, 32'h0);
                push_item(16'h4000, 16'hC000, 32'h8000_0000, 32'h0);
            end
            for (int n = 0; n < 200; n++)
                push_item(rand_steps(), rand_steps(), rand_goal(pose_x), rand_goal(pose_y));
        end

        drain();
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Input beat taken: predict its result.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            odometry_step(s_tdata);
            beat_in_taken = 1'b1;
        end
    end

    // Driver: present the next pending item after a random gap.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!(s_tvalid && !beat_in_taken)) begin
            wheel_item_t it;
            beat_in_taken = 1'b0;
            if (in_gap > 0) begin
                in_gap--;
                s_tvalid <= 1'b0;
            end else if (step_queue.size() > 0) begin
                it = step_queue.pop_front();
                s_tdata  <= {it.goal_y, it.goal_x, it.right_steps, it.left_steps};
                s_tvalid <= 1'b1;
                in_gap = gap_len();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure.
    always @(negedge aclk) begin
        if (out_gap > 0) begin
            out_gap--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            out_gap = gap_len();
        end
    end

    // Monitor: compare each result beat with the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            pose_result_t want;
            if (pose_expect.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result beat %h", m_tdata);
            end else begin
                want = pose_expect.pop_front();
                if (m_tdata[31:0] !== want.left_cmd || m_tdata[63:32] !== want.right_cmd ||
                    m_tdata[95:64] !== want.x || m_tdata[127:96] !== want.y ||
                    m_tdata[143:128] !== want.heading) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected L %h R %h X %h Y %h H %h, got %h",
                                 want.left_cmd, want.right_cmd, want.x, want.y,
                                 want.heading, m_tdata);
                end
            end
        end
    end

    // Watchdog on cycles without any beat or register write.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !aresetn) begin
            stall_count <= 0;
        end else if (stall_count >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

endmodule

`default_nettype wire
